// ===== sv/sgm_pkg.sv =====
// Package for the slice group map block: field words, request, status and map codes.
package sgm_pkg;

    localparam int MAP_UNITS     = 8192;
    localparam int MAP_AW        = 13;
    localparam int MAX_GROUPS    = 8;
    localparam int GROUP_W       = 3;
    localparam int MAX_WIDTH_MBS = 128;
    localparam int DIVD_W        = 14;
    localparam int DIVS_W        = 8;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [1:0] REQ_LOAD_PARAMS   = 2'd0;
    localparam logic [1:0] REQ_LOAD_EXPLICIT = 2'd1;
    localparam logic [1:0] REQ_BUILD         = 2'd2;
    localparam logic [1:0] REQ_QUERY         = 2'd3;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_PICTURE = 2'd1;
    localparam logic [1:0] STATUS_GROUPS      = 2'd2;

    localparam logic [2:0] MAP_INTERLEAVED = 3'd0;
    localparam logic [2:0] MAP_DISPERSED   = 3'd1;
    localparam logic [2:0] MAP_BOXES       = 3'd2;
    localparam logic [2:0] MAP_BOX_OUT     = 3'd3;
    localparam logic [2:0] MAP_RASTER      = 3'd4;
    localparam logic [2:0] MAP_WIPE        = 3'd5;
    localparam logic [2:0] MAP_EXPLICIT    = 3'd6;

    localparam logic [2:0] CFG_WIDTH      = 3'd0;
    localparam logic [2:0] CFG_HEIGHT     = 3'd1;
    localparam logic [2:0] CFG_GROUPS_M1  = 3'd2;
    localparam logic [2:0] CFG_MAP_KIND   = 3'd3;
    localparam logic [2:0] CFG_DIRECTION  = 3'd4;
    localparam logic [2:0] CFG_RATE_M1    = 3'd5;
    localparam logic [2:0] CFG_FRAME_ONLY = 3'd6;
    localparam logic [2:0] CFG_AFF        = 3'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  group_index;
        logic [12:0] run_length_minus_one;
        logic [12:0] box_top_left;
        logic [12:0] box_bottom_right;
        logic [12:0] unit_index;
        logic [2:0]  explicit_group;
        logic        field_picture;
        logic [13:0] change_cycle;
        logic [13:0] mb_address;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  done_kind;
        logic [14:0] next_address;
        logic [2:0]  group_of_address;
        logic [1:0]  status;
    } t_out_word;

endpackage

// ===== sv/sgm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sgm_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 3
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sgm_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by box corners and field queries.
module sgm_div import sgm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quot,
    output logic [DIVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_quot;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_divisor;
    logic [DIVS_W:0]   trial;
    logic              fits;

    always_comb begin
        trial = {r_rem, r_quot[DIVD_W-1]};
        fits  = (trial >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_quot    <= i_dividend;
                r_rem     <= '0;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                r_quot <= {r_quot[DIVD_W-2:0], fits};
                r_rem  <= fits ? DIVS_W'(trial - {1'b0, r_divisor}) : trial[DIVS_W-1:0];
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== sv/slice_group_map_next_mb.sv =====
// Top level: sequencer that builds the slice group map and answers next-address queries.
//
// One command word is taken at a clock edge with start high and busy low. Every word
// gives exactly one result word on o_word, marked by o_strobe for one cycle; the
// receiver cannot stall it. Configuration writes go through i_cfg_we/index/data and take
// effect at once; the user must make them only while the block is idle, which the block
// itself does not enforce. Loading group parameters or an explicit id: result in the
// following cycle, busy stays low. A build writes the map unit by unit (interleaved,
// dispersed, raster, wipe, fill); explicit maps read and then write each unit;
// foreground boxes run two divisions per group, then write each box unit; box-out
// fills the map, then takes an address, a read and a check state per spiral step.
// A query runs size and check states (plus one division for frame pictures without
// MBAFF in a sequence that is not frame-only), then a read and a compare state per
// macroblock walked. The single unit-group RAM port and the shared multiplier/divider
// set this pacing. Reset returns the sequencer to idle, the registers to their reset
// values and the built field flag to zero; the map stores are undefined until written.
module slice_group_map_next_mb import sgm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_in_word               i_word,
    output logic                   o_strobe,
    output t_out_word              o_word,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_B_SIZE, ST_B_CHK, ST_B_SEL, ST_FILL, ST_INTL, ST_DISP, ST_WIPE,
        ST_RAST, ST_EX_RD, ST_EX_WR, ST_BX_DIV1, ST_BX_WAIT1, ST_BX_DIV2, ST_BX_WAIT2,
        ST_BX_ROW, ST_BO_ADDR, ST_BO_RD, ST_BO_CHK, ST_Q_SIZE, ST_Q_CHK, ST_Q_SZ2,
        ST_Q_DIV, ST_Q_WAIT, ST_Q_BASE, ST_Q_BASE2, ST_Q_RD, ST_Q_CMP
    } t_state;

    typedef enum logic [1:0] {QM_DIRECT, QM_PAIR, QM_FIELD} t_qmode;

    t_state r_state;

    logic [7:0]  r_w, r_h;
    logic [2:0]  r_gm1, r_kind;
    logic        r_dir, r_fo, r_aff, r_bfp;
    logic [12:0] r_rate;
    logic [12:0] r_rl [MAX_GROUPS];
    logic [12:0] r_bs [MAX_GROUPS];
    logic [12:0] r_be [MAX_GROUPS];

    t_in_word    r_in;
    logic [27:0] r_prod;
    logic [13:0] r_size, r_m0, r_upper, r_i, r_k;
    logic [2:0]  r_g, r_fill_val;
    logic        r_fill_zero;
    logic [12:0] r_j;
    logic [7:0]  r_x;
    logic [2:0]  r_xm, r_hm;
    logic        r_yodd;
    logic [2:0]  r_gi;
    logic [12:0] r_y0, r_y1, r_y;
    logic [7:0]  r_x0, r_x1, r_xc;
    logic [13:0] r_base;
    logic [7:0]  r_sx, r_sy, r_lb, r_tb, r_rb, r_bb;
    logic signed [1:0] r_xd, r_yd;
    logic [12:0] r_idx;
    logic [7:0]  r_row, r_col;
    logic [13:0] r_addr;
    logic [14:0] r_qsize, r_qi;
    logic [7:0]  r_qc;
    logic        r_qhalf, r_first, r_uok;
    logic [13:0] r_qbase;
    t_qmode      r_qmode;
    t_out_word   r_out;
    logic        r_strobe;

    logic [13:0] mul_a, mul_b;
    logic              ug_we;
    logic [MAP_AW-1:0] ug_waddr, ug_raddr;
    logic [2:0]        ug_wdata, ug_rdata;
    logic              ex_we;
    logic [2:0]        ex_rdata;
    logic              div_start, div_done;
    logic [DIVD_W-1:0] div_dividend, div_quot;
    logic [DIVS_W-1:0] div_rem;

    logic        accept;
    logic [3:0]  n_groups, disp_sum, disp_g, hm_delta, hm_sum;
    logic [7:0]  wm1, hm1;
    logic [8:0]  hq;
    logic        pic_ok, vacant;
    logic [13:0] bo_idx, q_unit;
    logic [7:0]  n_sx, n_sy, n_lb, n_tb, n_rb, n_bb;
    logic signed [1:0] n_xd, n_yd;
    logic [27:0] m0_full;
    logic [13:0] m0_clamped;
    logic [13:0] y1_clamped;
    logic [2:0]  q_gv;
    logic [14:0] qi_next;

    function automatic t_out_word make_out(input logic [1:0] k, input logic [14:0] na,
                                           input logic [2:0] g, input logic [1:0] st);
        t_out_word o;
        o.done_kind        = k;
        o.next_address     = na;
        o.group_of_address = g;
        o.status           = st;
        return o;
    endfunction

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_groups = {1'b0, r_gm1} + 4'd1;
        wm1      = r_w - 8'd1;
        hm1      = r_h - 8'd1;
        pic_ok   = (r_w != 8'd0) && (r_h != 8'd0) && (r_w <= 8'(MAX_WIDTH_MBS)) &&
                   (r_prod[15:0] <= 16'(MAP_UNITS));
        if (r_fo) begin
            hq = r_bfp ? {2'b0, r_h[7:1]} : {1'b0, r_h};
        end else begin
            hq = r_bfp ? {1'b0, r_h} : {r_h, 1'b0};
        end
        m0_full    = r_prod;
        m0_clamped = (m0_full > {14'd0, r_size}) ? r_size : m0_full[13:0];
        y1_clamped = (div_quot > {6'd0, hm1}) ? {6'd0, hm1} : div_quot;

        // dispersed: group = (x mod n + floor(y*n/2) mod n) mod n, tracked per row
        disp_sum = {1'b0, r_xm} + {1'b0, r_hm};
        disp_g   = (disp_sum >= n_groups) ? disp_sum - n_groups : disp_sum;
        if (!r_gm1[0]) begin
            hm_delta = r_yodd ? (n_groups + 4'd1) >> 1 : (n_groups - 4'd1) >> 1;
        end else begin
            hm_delta = n_groups >> 1;
        end
        hm_sum = {1'b0, r_hm} + hm_delta;
        if (hm_sum >= n_groups) begin
            hm_sum = hm_sum - n_groups;
        end

        bo_idx = r_prod[13:0] + {6'd0, r_sx};
        vacant = (ug_rdata == 3'd1);

        case (r_qmode)
            QM_DIRECT: q_unit = r_qi[13:0];
            QM_PAIR:   q_unit = {1'b0, r_qi[13:1]};
            default:   q_unit = r_qbase + {6'd0, r_qc};
        endcase
        q_gv    = r_uok ? ug_rdata : 3'd0;
        qi_next = r_qi + 15'd1;
    end

    // box-out spiral step
    always_comb begin
        n_sx = r_sx; n_sy = r_sy; n_lb = r_lb; n_tb = r_tb; n_rb = r_rb; n_bb = r_bb;
        n_xd = r_xd; n_yd = r_yd;
        if (r_xd == -2'sd1 && r_sx == r_lb) begin
            n_lb = (r_lb != 8'd0) ? r_lb - 8'd1 : 8'd0;
            n_sx = n_lb;
            n_xd = 2'sd0;
            n_yd = r_dir ? 2'sd1 : -2'sd1;
        end else if (r_xd == 2'sd1 && r_sx == r_rb) begin
            n_rb = ({1'b0, r_rb} + 9'd1 < {1'b0, wm1}) ? r_rb + 8'd1 : wm1;
            n_sx = n_rb;
            n_xd = 2'sd0;
            n_yd = r_dir ? -2'sd1 : 2'sd1;
        end else if (r_yd == -2'sd1 && r_sy == r_tb) begin
            n_tb = (r_tb != 8'd0) ? r_tb - 8'd1 : 8'd0;
            n_sy = n_tb;
            n_xd = r_dir ? -2'sd1 : 2'sd1;
            n_yd = 2'sd0;
        end else if (r_yd == 2'sd1 && r_sy == r_bb) begin
            n_bb = ({1'b0, r_bb} + 9'd1 < {1'b0, hm1}) ? r_bb + 8'd1 : hm1;
            n_sy = n_bb;
            n_xd = r_dir ? 2'sd1 : -2'sd1;
            n_yd = 2'sd0;
        end else begin
            n_sx = r_sx + {{6{r_xd[1]}}, r_xd};
            n_sy = r_sy + {{6{r_yd[1]}}, r_yd};
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = 14'd0;
        mul_b = 14'd0;
        case (r_state)
            ST_B_SIZE, ST_Q_SIZE: begin
                mul_a = {6'd0, r_w};
                mul_b = {6'd0, r_h};
            end
            ST_B_CHK: begin
                mul_a = r_in.change_cycle;
                mul_b = {1'b0, r_rate} + 14'd1;
            end
            ST_Q_CHK: begin
                mul_a = {6'd0, r_w};
                mul_b = {5'd0, hq};
            end
            ST_BX_WAIT2: begin
                mul_a = {1'b0, r_y0};
                mul_b = {6'd0, r_w};
            end
            ST_BO_ADDR: begin
                mul_a = {6'd0, r_sy};
                mul_b = {6'd0, r_w};
            end
            ST_Q_BASE: begin
                mul_a = {1'b0, div_quot[13:1]};
                mul_b = {6'd0, r_w};
            end
            default: begin
                mul_a = 14'd0;
                mul_b = 14'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // RAM and divider controls
    always_comb begin
        ug_we    = 1'b0;
        ug_waddr = r_i[12:0];
        ug_wdata = 3'd0;
        ug_raddr = '0;
        case (r_state)
            ST_FILL: begin
                ug_we    = 1'b1;
                ug_wdata = r_fill_val;
            end
            ST_INTL: begin
                ug_we    = 1'b1;
                ug_wdata = r_g;
            end
            ST_DISP: begin
                ug_we    = 1'b1;
                ug_wdata = disp_g[2:0];
            end
            ST_WIPE: begin
                ug_we    = 1'b1;
                ug_wdata = {2'b0, (r_i < r_upper) ? r_dir : !r_dir};
            end
            ST_RAST: begin
                ug_we    = 1'b1;
                ug_waddr = r_addr[12:0];
                ug_wdata = {2'b0, (r_k < r_upper) ? r_dir : !r_dir};
            end
            ST_EX_WR: begin
                ug_we    = 1'b1;
                ug_wdata = ex_rdata;
            end
            ST_BX_ROW: begin
                ug_we    = 1'b1;
                ug_waddr = 13'(r_base + {6'd0, r_xc});
                ug_wdata = r_gi;
            end
            ST_BO_RD: begin
                ug_raddr = bo_idx[12:0];
            end
            ST_BO_CHK: begin
                ug_we    = vacant;
                ug_waddr = r_idx;
                ug_wdata = 3'd0;
            end
            ST_Q_RD: begin
                ug_raddr = q_unit[12:0];
            end
            default: begin
                ug_we = 1'b0;
            end
        endcase
    end

    assign ex_we     = accept && (i_word.req_type == REQ_LOAD_EXPLICIT);
    assign div_start = (r_state == ST_BX_DIV1) || (r_state == ST_BX_DIV2) ||
                       (r_state == ST_Q_DIV);

    always_comb begin
        case (r_state)
            ST_BX_DIV1: div_dividend = {1'b0, r_bs[r_gi]};
            ST_BX_DIV2: div_dividend = {1'b0, r_be[r_gi]};
            default:    div_dividend = r_in.mb_address;
        endcase
    end

    sgm_ram #(.ADDR_W(MAP_AW), .DATA_W(GROUP_W)) u_unit_ram (
        .i_clk   (i_clk),
        .i_we    (ug_we),
        .i_waddr (ug_waddr),
        .i_wdata (ug_wdata),
        .i_raddr (ug_raddr),
        .o_rdata (ug_rdata)
    );

    sgm_ram #(.ADDR_W(MAP_AW), .DATA_W(GROUP_W)) u_expl_ram (
        .i_clk   (i_clk),
        .i_we    (ex_we),
        .i_waddr (i_word.unit_index),
        .i_wdata (i_word.explicit_group),
        .i_raddr (r_i[12:0]),
        .o_rdata (ex_rdata)
    );

    sgm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_w),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_w      <= 8'd1;
            r_h      <= 8'd1;
            r_gm1    <= 3'd0;
            r_kind   <= 3'd0;
            r_dir    <= 1'b0;
            r_rate   <= 13'd0;
            r_fo     <= 1'b1;
            r_aff    <= 1'b0;
            r_bfp    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:      r_w    <= i_cfg_data[7:0];
                    CFG_HEIGHT:     r_h    <= i_cfg_data[7:0];
                    CFG_GROUPS_M1:  r_gm1  <= i_cfg_data[2:0];
                    CFG_MAP_KIND:   r_kind <= i_cfg_data[2:0];
                    CFG_DIRECTION:  r_dir  <= i_cfg_data[0];
                    CFG_RATE_M1:    r_rate <= i_cfg_data;
                    CFG_FRAME_ONLY: r_fo   <= i_cfg_data[0];
                    CFG_AFF:        r_aff  <= i_cfg_data[0];
                    default:        r_aff  <= r_aff;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_in <= i_word;
                        case (i_word.req_type)
                            REQ_LOAD_PARAMS: begin
                                r_rl[i_word.group_index] <= i_word.run_length_minus_one;
                                r_bs[i_word.group_index] <= i_word.box_top_left;
                                r_be[i_word.group_index] <= i_word.box_bottom_right;
                                r_out    <= make_out(REQ_LOAD_PARAMS, 15'd0, 3'd0, STATUS_OK);
                                r_strobe <= 1'b1;
                            end
                            REQ_LOAD_EXPLICIT: begin
                                r_out    <= make_out(REQ_LOAD_EXPLICIT, 15'd0, 3'd0,
                                                     STATUS_OK);
                                r_strobe <= 1'b1;
                            end
                            REQ_BUILD: begin
                                r_bfp   <= i_word.field_picture;
                                r_state <= ST_B_SIZE;
                            end
                            default: begin
                                r_state <= ST_Q_SIZE;
                            end
                        endcase
                    end
                end
                ST_B_SIZE: begin
                    r_state <= ST_B_CHK;
                end
                ST_B_CHK: begin
                    r_size <= r_prod[13:0];
                    r_i    <= 14'd0;
                    if (!pic_ok) begin
                        r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_BAD_PICTURE);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else if (r_gm1 == 3'd0 || r_kind > MAP_EXPLICIT) begin
                        r_fill_val  <= 3'd0;
                        r_fill_zero <= 1'b1;
                        r_state     <= ST_FILL;
                    end else if (r_kind >= MAP_BOX_OUT && r_kind <= MAP_WIPE &&
                                 r_gm1 != 3'd1) begin
                        r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_GROUPS);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_B_SEL;
                    end
                end
                ST_B_SEL: begin
                    r_m0        <= m0_clamped;
                    r_upper     <= r_dir ? r_size - m0_clamped : m0_clamped;
                    r_g         <= 3'd0;
                    r_j         <= 13'd0;
                    r_x         <= 8'd0;
                    r_xm        <= 3'd0;
                    r_hm        <= 3'd0;
                    r_yodd      <= 1'b0;
                    r_row       <= 8'd0;
                    r_col       <= 8'd0;
                    r_addr      <= 14'd0;
                    r_k         <= 14'd0;
                    r_gi        <= 3'(n_groups - 4'd2);
                    r_fill_zero <= 1'b0;
                    r_sx        <= (r_w - {7'd0, r_dir}) >> 1;
                    r_sy        <= (r_h - {7'd0, r_dir}) >> 1;
                    r_lb        <= (r_w - {7'd0, r_dir}) >> 1;
                    r_rb        <= (r_w - {7'd0, r_dir}) >> 1;
                    r_tb        <= (r_h - {7'd0, r_dir}) >> 1;
                    r_bb        <= (r_h - {7'd0, r_dir}) >> 1;
                    r_xd        <= r_dir ? 2'sd0 : -2'sd1;
                    r_yd        <= r_dir ? 2'sd1 : 2'sd0;
                    case (r_kind)
                        MAP_INTERLEAVED: r_state <= ST_INTL;
                        MAP_DISPERSED:   r_state <= ST_DISP;
                        MAP_BOXES: begin
                            r_fill_val <= r_gm1;
                            r_state    <= ST_FILL;
                        end
                        MAP_BOX_OUT: begin
                            r_fill_val <= 3'd1;
                            r_state    <= ST_FILL;
                        end
                        MAP_RASTER:      r_state <= ST_WIPE;
                        MAP_WIPE:        r_state <= ST_RAST;
                        default:         r_state <= ST_EX_RD;
                    endcase
                end
                ST_FILL: begin
                    r_i <= r_i + 14'd1;
                    if (r_i == r_size - 14'd1) begin
                        if (r_fill_zero || (r_kind == MAP_BOX_OUT && r_m0 == 14'd0)) begin
                            r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_OK);
                            r_strobe <= 1'b1;
                            r_state  <= ST_IDLE;
                        end else if (r_kind == MAP_BOXES) begin
                            r_state <= ST_BX_DIV1;
                        end else begin
                            r_state <= ST_BO_ADDR;
                        end
                    end
                end
                ST_INTL: begin
                    r_i <= r_i + 14'd1;
                    if (r_j == r_rl[r_g]) begin
                        r_j <= 13'd0;
                        r_g <= (r_g == r_gm1) ? 3'd0 : r_g + 3'd1;
                    end else begin
                        r_j <= r_j + 13'd1;
                    end
                    if (r_i == r_size - 14'd1) begin
                        r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_OK);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_DISP: begin
                    r_i <= r_i + 14'd1;
                    if (r_x == wm1) begin
                        r_x    <= 8'd0;
                        r_xm   <= 3'd0;
                        r_yodd <= !r_yodd;
                        r_hm   <= hm_sum[2:0];
                    end else begin
                        r_x  <= r_x + 8'd1;
                        r_xm <= (r_xm == r_gm1) ? 3'd0 : r_xm + 3'd1;
                    end
                    if (r_i == r_size - 14'd1) begin
                        r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_OK);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_WIPE: begin
                    r_i <= r_i + 14'd1;
                    if (r_i == r_size - 14'd1) begin
                        r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_OK);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_RAST: begin
                    // column-major walk
                    r_k <= r_k + 14'd1;
                    if (r_row == hm1) begin
                        r_row  <= 8'd0;
                        r_col  <= r_col + 8'd1;
                        r_addr <= {6'd0, r_col} + 14'd1;
                    end else begin
                        r_row  <= r_row + 8'd1;
                        r_addr <= r_addr + {6'd0, r_w};
                    end
                    if (r_k == r_size - 14'd1) begin
                        r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_OK);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_EX_RD: begin
                    r_state <= ST_EX_WR;
                end
                ST_EX_WR: begin
                    r_i <= r_i + 14'd1;
                    if (r_i == r_size - 14'd1) begin
                        r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_OK);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_EX_RD;
                    end
                end
                ST_BX_DIV1: begin
                    r_state <= ST_BX_WAIT1;
                end
                ST_BX_WAIT1: begin
                    if (div_done) begin
                        r_y0    <= div_quot[12:0];
                        r_x0    <= div_rem;
                        r_state <= ST_BX_DIV2;
                    end
                end
                ST_BX_DIV2: begin
                    r_state <= ST_BX_WAIT2;
                end
                ST_BX_WAIT2: begin
                    if (div_done) begin
                        r_y1   <= y1_clamped[12:0];
                        r_x1   <= div_rem;
                        r_y    <= r_y0;
                        r_xc   <= r_x0;
                        r_base <= r_prod[13:0];
                        if ({1'b0, r_y0} > y1_clamped || r_x0 > div_rem) begin
                            if (r_gi == 3'd0) begin
                                r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_OK);
                                r_strobe <= 1'b1;
                                r_state  <= ST_IDLE;
                            end else begin
                                r_gi    <= r_gi - 3'd1;
                                r_state <= ST_BX_DIV1;
                            end
                        end else begin
                            r_state <= ST_BX_ROW;
                        end
                    end
                end
                ST_BX_ROW: begin
                    if (r_xc == r_x1) begin
                        r_xc <= r_x0;
                        if (r_y == r_y1) begin
                            if (r_gi == 3'd0) begin
                                r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_OK);
                                r_strobe <= 1'b1;
                                r_state  <= ST_IDLE;
                            end else begin
                                r_gi    <= r_gi - 3'd1;
                                r_state <= ST_BX_DIV1;
                            end
                        end else begin
                            r_y    <= r_y + 13'd1;
                            r_base <= r_base + {6'd0, r_w};
                        end
                    end else begin
                        r_xc <= r_xc + 8'd1;
                    end
                end
                ST_BO_ADDR: begin
                    r_state <= ST_BO_RD;
                end
                ST_BO_RD: begin
                    r_idx   <= bo_idx[12:0];
                    r_state <= ST_BO_CHK;
                end
                ST_BO_CHK: begin
                    r_k  <= r_k + {13'd0, vacant};
                    r_sx <= n_sx;
                    r_sy <= n_sy;
                    r_lb <= n_lb;
                    r_tb <= n_tb;
                    r_rb <= n_rb;
                    r_bb <= n_bb;
                    r_xd <= n_xd;
                    r_yd <= n_yd;
                    if (r_k + {13'd0, vacant} == r_m0) begin
                        r_out    <= make_out(REQ_BUILD, 15'd0, 3'd0, STATUS_OK);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_BO_ADDR;
                    end
                end
                ST_Q_SIZE: begin
                    r_state <= ST_Q_CHK;
                end
                ST_Q_CHK: begin
                    if (!pic_ok) begin
                        r_out    <= make_out(REQ_QUERY, 15'd0, 3'd0, STATUS_BAD_PICTURE);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_Q_SZ2;
                    end
                end
                ST_Q_SZ2: begin
                    r_qsize <= r_prod[14:0];
                    r_qi    <= {1'b0, r_in.mb_address};
                    r_first <= 1'b1;
                    r_qc    <= 8'd0;
                    r_qhalf <= 1'b0;
                    r_qbase <= 14'd0;
                    if ({1'b0, r_in.mb_address} >= r_prod[14:0]) begin
                        r_out    <= make_out(REQ_QUERY, r_prod[14:0], 3'd0, STATUS_OK);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else if (r_fo || r_bfp) begin
                        r_qmode <= QM_DIRECT;
                        r_state <= ST_Q_RD;
                    end else if (r_aff) begin
                        r_qmode <= QM_PAIR;
                        r_state <= ST_Q_RD;
                    end else begin
                        r_qmode <= QM_FIELD;
                        r_state <= ST_Q_DIV;
                    end
                end
                ST_Q_DIV: begin
                    r_state <= ST_Q_WAIT;
                end
                ST_Q_WAIT: begin
                    if (div_done) begin
                        r_qc    <= div_rem;
                        r_qhalf <= div_quot[0];
                        r_state <= ST_Q_BASE;
                    end
                end
                ST_Q_BASE: begin
                    r_state <= ST_Q_BASE2;
                end
                ST_Q_BASE2: begin
                    r_qbase <= r_prod[13:0];
                    r_state <= ST_Q_RD;
                end
                ST_Q_RD: begin
                    r_uok   <= !q_unit[13];
                    r_state <= ST_Q_CMP;
                end
                ST_Q_CMP: begin
                    if (r_first) begin
                        r_g     <= q_gv;
                        r_first <= 1'b0;
                    end
                    if (!r_first && q_gv == r_g) begin
                        r_out    <= make_out(REQ_QUERY, r_qi, r_g, STATUS_OK);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else if (qi_next == r_qsize) begin
                        r_out    <= make_out(REQ_QUERY, r_qsize, r_first ? q_gv : r_g,
                                             STATUS_OK);
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_qi <= qi_next;
                        // field map of a frame picture: two macroblock rows per unit row
                        if (r_qc == wm1) begin
                            r_qc    <= 8'd0;
                            r_qhalf <= !r_qhalf;
                            if (r_qhalf) begin
                                r_qbase <= r_qbase + {6'd0, r_w};
                            end
                        end else begin
                            r_qc <= r_qc + 8'd1;
                        end
                        r_state <= ST_Q_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_out;

    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_strobe))
        else $error("accepted word neither started work nor answered");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result word while sequencer still busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_word.status != 2'd3))
        else $error("undefined status code");

    a_non_query_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.done_kind != REQ_QUERY) |->
        (o_word.next_address == 15'd0 && o_word.group_of_address == 3'd0))
        else $error("non-query result carries address or group");

endmodule
